// File: rtl/core/symc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symc_pkg: shared constants and types for the symmetrical components block
// fixed-point formats, cordic arctangent table and angle helpers
// ----------------------------------------------------------------------------
package symc_pkg;

	localparam int MAG_BITS     = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int FRAC_BITS    = 14;
	localparam int TABLE_LEN    = 24;
	localparam int NSTEP        = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

	// rectangular width: mag*invk < 2^(MAG_BITS+FRAC_BITS), three sums plus growth
	localparam int RW = MAG_BITS + FRAC_BITS + 4;
	// cordic angle width, units of 1/25600 degree
	localparam int ZW = 27;
	localparam int AW = 17;

	localparam logic [29:0] INV_K_Q30 = 30'd652032874;
	localparam logic [29:0] SCALE_Q32 = 30'd869377165;

	localparam logic signed [ZW-1:0] ZPI = ZW'(18000 * 256);

	typedef logic signed [RW-1:0] rect_t;
	typedef logic signed [ZW-1:0] zang_t;

	function automatic zang_t atan_c(input int i);
		case (i)
			0: atan_c = ZW'(1152000);  1: atan_c = ZW'(680065);
			2: atan_c = ZW'(359328);   3: atan_c = ZW'(182400);
			4: atan_c = ZW'(91554);    5: atan_c = ZW'(45822);
			6: atan_c = ZW'(22916);    7: atan_c = ZW'(11459);
			8: atan_c = ZW'(5730);     9: atan_c = ZW'(2865);
			10: atan_c = ZW'(1432);    11: atan_c = ZW'(716);
			12: atan_c = ZW'(358);     13: atan_c = ZW'(179);
			14: atan_c = ZW'(90);      15: atan_c = ZW'(45);
			16: atan_c = ZW'(22);      17: atan_c = ZW'(11);
			18: atan_c = ZW'(6);       19: atan_c = ZW'(3);
			20: atan_c = ZW'(1);       21: atan_c = ZW'(1);
			default: atan_c = '0;
		endcase
	endfunction

endpackage

// File: rtl/core/symc_rot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symc_rot: polar to rectangular lane
// pipelined cordic rotation, one stage per step, with quadrant fold
// ----------------------------------------------------------------------------
module symc_rot import symc_pkg::*; (
	input  logic                  clk,
	input  logic                  en,
	input  logic [MAG_BITS-1:0]   mag,
	input  logic signed [AW:0]    ang,
	output rect_t                 re,
	output rect_t                 im
);

	logic signed [AW:0] r0, r1, r2;
	logic                flip;
	logic [MAG_BITS+29:0] prod;

	rect_t x_s [NSTEP+1];
	rect_t y_s [NSTEP+1];
	zang_t z_s [NSTEP+1];
	logic  f_s [NSTEP+1];

	// reduce modulo one turn: input within -65536..89535
	always_comb begin
		r0 = ang;
		if (r0 >= 36000) r0 = r0 - (AW+1)'(36000);
		if (r0 >= 36000) r0 = r0 - (AW+1)'(36000);
		if (r0 <= -36000) r0 = r0 + (AW+1)'(36000);
		if (r0 < 0) r0 = r0 + (AW+1)'(36000);
		r1 = (r0 > 18000) ? r0 - (AW+1)'(36000) : r0;
		flip = 1'b0;
		r2 = r1;
		if (r1 > 9000) begin
			r2 = r1 - (AW+1)'(18000);
			flip = 1'b1;
		end else if (r1 < -9000) begin
			r2 = r1 + (AW+1)'(18000);
			flip = 1'b1;
		end
		prod = MAG_BITS'(mag) * INV_K_Q30;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= RW'(signed'({1'b0, prod[MAG_BITS+29:30-FRAC_BITS]}));
			y_s[0] <= '0;
			z_s[0] <= ZW'(r2) <<< 8;
			f_s[0] <= flip;
		end
	end

	for (genvar i = 0; i < NSTEP; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_c(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_c(i);
				end
				f_s[i+1] <= f_s[i];
			end
		end
	end

	assign re = f_s[NSTEP] ? -x_s[NSTEP] : x_s[NSTEP];
	assign im = f_s[NSTEP] ? -y_s[NSTEP] : y_s[NSTEP];

endmodule

// File: rtl/core/symc_vec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symc_vec: rectangular to polar lane
// pipelined cordic vectoring, gain and third removed by one multiply
// ----------------------------------------------------------------------------
module symc_vec import symc_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  rect_t               x,
	input  rect_t               y,
	output logic [15:0]         mag,
	output logic signed [15:0]  ang
);

	rect_t x_s [NSTEP+1];
	rect_t y_s [NSTEP+1];
	zang_t z_s [NSTEP+1];
	logic  zv_s [NSTEP+1];

	always_ff @(posedge clk) begin
		if (en) begin
			zv_s[0] <= (x == 0) && (y == 0);
			if (x < 0) begin
				x_s[0] <= -x;
				y_s[0] <= -y;
				z_s[0] <= ZPI;
			end else begin
				x_s[0] <= x;
				y_s[0] <= y;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < NSTEP; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_c(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_c(i);
				end
				zv_s[i+1] <= zv_s[i];
			end
		end
	end

	// scale stage: two partial products, registered
	localparam int UW = RW + 2;
	logic [UW-1:0] ux;
	logic [UW+29:0] phi_s1, plo_s1;
	zang_t          z_s1;
	logic           zv_s1;
	assign ux = x_s[NSTEP][RW-1] ? '0 : UW'(unsigned'(x_s[NSTEP]));

	always_ff @(posedge clk) begin
		if (en) begin
			phi_s1 <= (UW+30)'(ux >> 16) * SCALE_Q32;
			plo_s1 <= (UW+30)'(ux[15:0]) * SCALE_Q32;
			z_s1   <= z_s[NSTEP];
			zv_s1  <= zv_s[NSTEP];
		end
	end

	logic [UW+29:0] t, m;
	zang_t          h0, h;
	always_comb begin
		t = phi_s1 + (plo_s1 >> 16);
		m = (t + ((UW+30)'(1) << (15 + FRAC_BITS))) >> (16 + FRAC_BITS);
		if (m > (UW+30)'((64'd1 << MAG_BITS) - 1)) m = (UW+30)'((64'd1 << MAG_BITS) - 1);
		h0 = (z_s1 + ZW'(128)) >>> 8;
		h = h0;
		if (h0 > 18000) h = h0 - ZW'(36000);
		else if (h0 < -18000) h = h0 + ZW'(36000);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag <= zv_s1 ? '0 : m[15:0];
			ang <= zv_s1 ? '0 : h[15:0];
		end
	end

endmodule

// File: rtl/core/symmetrical_components.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetrical_components: fortescue sequence components of a phasor set
// ----------------------------------------------------------------------------
// input channel: in_valid/in_ready with three phase magnitudes and angles
// (hundredths of a degree). output channel: out_valid/out_ready with positive,
// negative and zero sequence magnitude and angle.
// seven rotation lanes turn the phasors (with 120 and 240 degree offsets) to
// rectangular form, a merging adder forms the three sums, and three vectoring
// lanes return them to polar form.
// one beat is taken every cycle while the pipeline advances.
// the whole pipeline advances only while the output register is free or
// being drained, so a stalled receiver holds every stage in place and
// in_ready falls with it.
// reset clears the valid flags only; payload registers are not reset.
// ----------------------------------------------------------------------------
module symmetrical_components import symc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        mag_phase_a,
	input  logic signed [16:0] ang_phase_a,
	input  logic [15:0]        mag_phase_b,
	input  logic signed [16:0] ang_phase_b,
	input  logic [15:0]        mag_phase_c,
	input  logic signed [16:0] ang_phase_c,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        pos_mag,
	output logic signed [15:0] pos_ang,
	output logic [15:0]        neg_mag,
	output logic signed [15:0] neg_ang,
	output logic [15:0]        zero_mag,
	output logic signed [15:0] zero_ang
);

	localparam int LAT = 2 * NSTEP + 5;

	logic            en;
	logic [LAT-1:0]  vld_q;

	assign en       = !vld_q[LAT-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	logic [MAG_BITS-1:0] lm [7];
	logic signed [AW:0]  la [7];
	rect_t               lr [7];
	rect_t               li [7];

	always_comb begin
		lm[0] = mag_phase_a[MAG_BITS-1:0]; la[0] = (AW+1)'(ang_phase_a);
		lm[1] = mag_phase_b[MAG_BITS-1:0]; la[1] = (AW+1)'(ang_phase_b);
		lm[2] = mag_phase_b[MAG_BITS-1:0]; la[2] = (AW+1)'(ang_phase_b) + (AW+1)'(12000);
		lm[3] = mag_phase_b[MAG_BITS-1:0]; la[3] = (AW+1)'(ang_phase_b) + (AW+1)'(24000);
		lm[4] = mag_phase_c[MAG_BITS-1:0]; la[4] = (AW+1)'(ang_phase_c);
		lm[5] = mag_phase_c[MAG_BITS-1:0]; la[5] = (AW+1)'(ang_phase_c) + (AW+1)'(12000);
		lm[6] = mag_phase_c[MAG_BITS-1:0]; la[6] = (AW+1)'(ang_phase_c) + (AW+1)'(24000);
	end

	for (genvar k = 0; k < 7; k++) begin : g_rot
		symc_rot u_rot (
			.clk(clk), .en(en), .mag(lm[k]), .ang(la[k]), .re(lr[k]), .im(li[k])
		);
	end

	// merge stage: sequence sums
	rect_t px_s1, py_s1, nx_s1, ny_s1, zx_s1, zy_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= lr[0] + lr[2] + lr[6];
			py_s1 <= li[0] + li[2] + li[6];
			nx_s1 <= lr[0] + lr[3] + lr[5];
			ny_s1 <= li[0] + li[3] + li[5];
			zx_s1 <= lr[0] + lr[1] + lr[4];
			zy_s1 <= li[0] + li[1] + li[4];
		end
	end

	symc_vec u_pos (.clk(clk), .en(en), .x(px_s1), .y(py_s1), .mag(pos_mag), .ang(pos_ang));
	symc_vec u_neg (.clk(clk), .en(en), .x(nx_s1), .y(ny_s1), .mag(neg_mag), .ang(neg_ang));
	symc_vec u_zer (.clk(clk), .en(en), .x(zx_s1), .y(zy_s1), .mag(zero_mag), .ang(zero_ang));

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_mag) && $stable(zero_ang))
		else $error("result changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("ready mismatch");
	a_ang_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pos_ang <= 18000 && pos_ang >= -18000)
		else $error("angle out of range");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: symmetrical components block testbench
// ----------------------------------------------------------------------------
// drives three-phase phasor sets into the block and checks the positive,
// negative and zero sequence results against an in-bench fixed-point
// prediction (cordic rotation, sequence sums, cordic vectoring). directed
// sets cover zero vectors, extreme magnitudes, angles past one turn and the
// half-turn normalisation edge; random sets follow under changing idle mixes.
// ----------------------------------------------------------------------------
module tb_top;
	import symc_pkg::*;

	typedef struct packed {
		logic [15:0]        pos_mag;
		logic signed [15:0] pos_ang;
		logic [15:0]        neg_mag;
		logic signed [15:0] neg_ang;
		logic [15:0]        zero_mag;
		logic signed [15:0] zero_ang;
	} seq_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [15:0]        mag_phase_a = '0;
	logic signed [16:0] ang_phase_a = '0;
	logic [15:0]        mag_phase_b = '0;
	logic signed [16:0] ang_phase_b = '0;
	logic [15:0]        mag_phase_c = '0;
	logic signed [16:0] ang_phase_c = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [15:0]        pos_mag, neg_mag, zero_mag;
	logic signed [15:0] pos_ang, neg_ang, zero_ang;

	seq_result_t expected_q[$];
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          errors = 0;
	int          beats_in = 0;
	int          beats_out = 0;

	localparam longint ATAN_TAB[24] = '{
		1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
		5730, 2865, 1432, 716, 358, 179, 90, 45,
		22, 11, 6, 3, 1, 1, 0, 0
	};
	localparam longint INVK = 64'd652032874;
	localparam longint unsigned SCALE = 64'd869377165;

	symmetrical_components dut (
		.clk, .arst_n, .in_valid, .in_ready,
		.mag_phase_a, .ang_phase_a, .mag_phase_b, .ang_phase_b,
		.mag_phase_c, .ang_phase_c,
		.out_valid, .out_ready,
		.pos_mag, .pos_ang, .neg_mag, .neg_ang, .zero_mag, .zero_ang
	);

	always #10 clk = ~clk;

	function automatic void polar_to_rect(input longint mag, input longint ang,
			output longint re, output longint im);
		longint r, x, y, z, dx, dy;
		bit flip;
		r = ang % 36000;
		flip = 1'b0;
		if (r < 0) r += 36000;
		if (r > 18000) r -= 36000;
		if (r > 9000) begin
			r -= 18000;
			flip = 1'b1;
		end else if (r < -9000) begin
			r += 18000;
			flip = 1'b1;
		end
		x = (mag * INVK) >>> (30 - FRAC_BITS);
		y = 0;
		z = r * 256;
		for (int i = 0; i < NSTEP; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_TAB[i];
			end else begin
				x += dx; y -= dy; z += ATAN_TAB[i];
			end
		end
		re = flip ? -x : x;
		im = flip ? -y : y;
	endfunction

	function automatic void rect_to_polar(input longint xi, input longint yi,
			output logic [15:0] mag, output logic signed [15:0] ang);
		longint x, y, z, dx, dy, h;
		longint unsigned ux, t, m;
		x = xi;
		y = yi;
		z = 0;
		if (x == 0 && y == 0) begin
			mag = '0;
			ang = '0;
			return;
		end
		if (x < 0) begin
			x = -x; y = -y; z = 18000 * 256;
		end
		for (int i = 0; i < NSTEP; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += ATAN_TAB[i];
			end else begin
				x -= dx; y += dy; z -= ATAN_TAB[i];
			end
		end
		ux = (x < 0) ? 0 : x;
		t = (ux >> 16) * SCALE + (((ux & 64'hFFFF) * SCALE) >> 16);
		m = (t + (64'd1 << (15 + FRAC_BITS))) >> (16 + FRAC_BITS);
		if (m > (64'd1 << MAG_BITS) - 1) m = (64'd1 << MAG_BITS) - 1;
		h = (z + 128) >>> 8;
		while (h > 18000) h -= 36000;
		while (h < -18000) h += 36000;
		mag = m[15:0];
		ang = h[15:0];
	endfunction

	function automatic seq_result_t sequence_components(input logic [15:0] ma,
			input logic signed [16:0] aa, input logic [15:0] mb,
			input logic signed [16:0] ab, input logic [15:0] mc,
			input logic signed [16:0] ac);
		longint mmask, ar, ai, b0r, b0i, b1r, b1i, b2r, b2i;
		longint c0r, c0i, c1r, c1i, c2r, c2i;
		seq_result_t res;
		mmask = (64'd1 << MAG_BITS) - 1;
		polar_to_rect(ma & mmask, aa, ar, ai);
		polar_to_rect(mb & mmask, ab, b0r, b0i);
		polar_to_rect(mb & mmask, longint'(ab) + 12000, b1r, b1i);
		polar_to_rect(mb & mmask, longint'(ab) + 24000, b2r, b2i);
		polar_to_rect(mc & mmask, ac, c0r, c0i);
		polar_to_rect(mc & mmask, longint'(ac) + 12000, c1r, c1i);
		polar_to_rect(mc & mmask, longint'(ac) + 24000, c2r, c2i);
		rect_to_polar(ar + b1r + c2r, ai + b1i + c2i, res.pos_mag, res.pos_ang);
		rect_to_polar(ar + b2r + c1r, ai + b2i + c1i, res.neg_mag, res.neg_ang);
		rect_to_polar(ar + b0r + c0r, ai + b0i + c0i, res.zero_mag, res.zero_ang);
		return res;
	endfunction

	task automatic send_phasors(input logic [15:0] ma, input logic signed [16:0] aa,
			input logic [15:0] mb, input logic signed [16:0] ab,
			input logic [15:0] mc, input logic signed [16:0] ac);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		mag_phase_a <= ma;
		ang_phase_a <= aa;
		mag_phase_b <= mb;
		ang_phase_b <= ab;
		mag_phase_c <= mc;
		ang_phase_c <= ac;
		do @(posedge clk); while (!in_ready);
		expected_q.push_back(sequence_components(ma, aa, mb, ab, mc, ac));
		beats_in++;
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		seq_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			beats_out++;
			if (expected_q.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				exp_r = expected_q.pop_front();
				if (pos_mag !== exp_r.pos_mag) begin
					$error("pos_mag expected %0d got %0d", exp_r.pos_mag, pos_mag);
					errors++;
				end
				if (pos_ang !== exp_r.pos_ang) begin
					$error("pos_ang expected %0d got %0d", exp_r.pos_ang, pos_ang);
					errors++;
				end
				if (neg_mag !== exp_r.neg_mag) begin
					$error("neg_mag expected %0d got %0d", exp_r.neg_mag, neg_mag);
					errors++;
				end
				if (neg_ang !== exp_r.neg_ang) begin
					$error("neg_ang expected %0d got %0d", exp_r.neg_ang, neg_ang);
					errors++;
				end
				if (zero_mag !== exp_r.zero_mag) begin
					$error("zero_mag expected %0d got %0d", exp_r.zero_mag, zero_mag);
					errors++;
				end
				if (zero_ang !== exp_r.zero_ang) begin
					$error("zero_ang expected %0d got %0d", exp_r.zero_ang, zero_ang);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		send_phasors(16'd0, 17'sd0, 16'd0, 17'sd0, 16'd0, 17'sd0);
		send_phasors(16'd65535, 17'sd0, 16'd65535, -17'sd12000, 16'd65535, 17'sd12000);
		send_phasors(16'd65535, 17'sd0, 16'd65535, 17'sd12000, 16'd65535, -17'sd12000);
		send_phasors(16'd65535, 17'sd4500, 16'd65535, 17'sd4500, 16'd65535, 17'sd4500);
		send_phasors(16'd1000, 17'sd36000, 16'd1000, -17'sd36000, 16'd1000, 17'sd18000);
		send_phasors(16'd1000, -17'sd18000, 16'd0, 17'sd0, 16'd0, 17'sd0);
		send_phasors(16'd1000, 17'sd18000, 16'd0, 17'sd0, 16'd0, 17'sd0);
		send_phasors(16'd1, 17'sd9000, 16'd1, -17'sd9000, 16'd1, 17'sd27000);
		send_phasors(16'd65535, 17'sh10000, 16'd65535, 17'sd65535, 16'd0, 17'sd100);
		send_phasors(16'd0, 17'sd65535, 16'd32768, 17'sh10000, 16'd1, -17'sd1);
		send_phasors(16'd65535, 17'sd35999, 16'd65535, -17'sd35999, 16'd65535, 17'sd17999);
		send_phasors(16'd500, 17'sd0, 16'd500, 17'sd0, 16'd0, 17'sd0);
		send_phasors(16'd12345, 17'sd9001, 16'd54321, -17'sd9001, 16'd777, 17'sd27001);
	endtask

	task automatic test_random(input int count, input int s_idle, input int r_idle);
		logic [15:0]        m[3];
		logic signed [16:0] a[3];
		int                 base;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		repeat (count) begin
			base = int'($urandom_range(36000)) - 18000;
			for (int k = 0; k < 3; k++) begin
				case ($urandom_range(9))
					0: m[k] = '0;
					1: m[k] = 16'hFFFF;
					default: m[k] = 16'($urandom);
				endcase
				case ($urandom_range(9))
					0: a[k] = 17'($urandom);
					1, 2: a[k] = 17'(base - k * 12000 + int'($urandom_range(200)) - 100);
					default: a[k] = 17'(int'($urandom_range(72000)) - 36000);
				endcase
			end
			send_phasors(m[0], a[0], m[1], a[1], m[2], a[2]);
		end
	endtask

	initial begin
		#10ms;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(630, 35, 70);
		test_random(630, 70, 35);
		test_random(630, 0, 0);
		in_valid <= 1'b0;
		recv_idle_pct = 20;
		wait (expected_q.size() == 0);
		repeat (CORDIC_STEPS * 2 + 20) @(posedge clk);
		$display("covered %0d phasor sets in, %0d sequence results out", beats_in, beats_out);
		$display("directed edges, balanced and full-range random sets, three idle mixes");
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
